@@ rtl/core/lsra_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// aligned span register allocator. No dependencies.
package lsra_pkg;

   // default sizing of the register class and position fields
   localparam int DEF_REGS      = 256;
   localparam int DEF_MAX_WIDTH = 16;
   localparam int DEF_POS_BITS  = 16;

   // occupancy is stored in chunks wide enough for the largest aligned window
   localparam int CHUNK_BITS = 32;
   localparam int CHUNK_LOG  = 5;

   // fixed field widths
   localparam int CSR_W    = 9;
   localparam int SPAN_W   = 5;
   localparam int STATUS_W = 2;
   localparam int BASE_W   = 8;
   localparam int LIVE_W   = 9;
   localparam int RELIEF_W = 5;
   localparam int RELIEF_MAX = 31;

   // request actions
   localparam logic ACT_BEGIN = 1'b0;
   localparam logic ACT_ALLOC = 1'b1;

   // configuration register indexes
   localparam logic CSR_NUM_REGS = 1'b0;
   localparam logic CSR_RESERVED = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STAT_ALLOC   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOREG   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BEGUN   = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic clear_class;
      logic refuse;
      logic expire_step;
      logic expire_end;
      logic top_step;
      logic bound_load;
      logic search_step;
      logic grant;
      logic fail;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_begin;
      logic overflowed;
      logic expire_done;
      logic top_done;
      logic search_hit;
      logic search_last;
   } sts_type;

endpackage

@@ rtl/core/lsra_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lsra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic                              rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lsra_ctrl.sv @@
// Sequencing state machine of the allocator: begin, refuse, expiry pass,
// top scan, bound setup, window search, grant or fail. Uses lsra_pkg.
module lsra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output lsra_pkg::cmd_type cmd,
   input  lsra_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_DISPATCH = 8'b0000_0010,
      ST_EXPIRE   = 8'b0000_0100,
      ST_TOP      = 8'b0000_1000,
      ST_BOUND    = 8'b0001_0000,
      ST_SEARCH   = 8'b0010_0000,
      ST_GRANT    = 8'b0100_0000,
      ST_FAIL     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.is_begin) begin
               cmd.clear_class = 1'b1;
               state_in        = ST_IDLE;
            end else if (sts.overflowed) begin
               cmd.refuse = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            if (sts.expire_done) begin
               cmd.expire_end = 1'b1;
               state_in       = ST_TOP;
            end else begin
               cmd.expire_step = 1'b1;
            end
         end
         ST_TOP: begin
            cmd.top_step = 1'b1;
            if (sts.top_done) begin
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            cmd.bound_load = 1'b1;
            state_in       = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (sts.search_hit) begin
               state_in = ST_GRANT;
            end else if (sts.search_last) begin
               state_in = ST_FAIL;
            end
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_FAIL: begin
            cmd.fail = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/core/lsra_dp.sv @@
// Datapath of the allocator: config registers, chunked occupancy map, active
// span table in RAM, expiry, top scan, aligned search and response registers.
// Uses lsra_pkg and lsra_ram.
module lsra_dp #(
   parameter int REGS      = lsra_pkg::DEF_REGS,
   parameter int MAX_WIDTH = lsra_pkg::DEF_MAX_WIDTH,
   parameter int POS_BITS  = lsra_pkg::DEF_POS_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsra_pkg::cmd_type                 cmd,
   output lsra_pkg::sts_type                 sts,
   input  logic                              req_action,
   input  logic [POS_BITS-1:0]               req_start_position,
   input  logic [POS_BITS-1:0]               req_end_position,
   input  logic [lsra_pkg::SPAN_W-1:0]       req_span_width,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [lsra_pkg::CSR_W-1:0]        csr_write_data,
   output logic                              rsp_valid,
   output logic [lsra_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lsra_pkg::BASE_W-1:0]       rsp_base_register,
   output logic [lsra_pkg::LIVE_W-1:0]       rsp_live_regs,
   output logic [lsra_pkg::RELIEF_W-1:0]     rsp_shortfall
);

   localparam int CH      = lsra_pkg::CHUNK_BITS;
   localparam int CB      = lsra_pkg::CHUNK_LOG;
   localparam int CB1     = CB + 1;
   localparam int IDX_W   = $clog2(REGS);
   localparam int CNT_W   = $clog2(REGS + 1);
   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int NCH     = (REGS + CH - 1) / CH;
   localparam int CI_W    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int ADR_W   = CI_W + CB;
   localparam int AW      = ((ADR_W > lsra_pkg::CSR_W) ? ADR_W : lsra_pkg::CSR_W) + 2;
   localparam int ENT_W   = IDX_W + WID_W + POS_BITS;
   localparam int LAST_N  = REGS - (NCH - 1) * CH;
   localparam int BASE_W  = lsra_pkg::BASE_W;
   localparam int LIVE_W  = lsra_pkg::LIVE_W;
   localparam int RELIEF_W = lsra_pkg::RELIEF_W;
   localparam logic [CH:0]   ONE_C    = 1;
   localparam logic [63:0]   LAST_ONE = (64'd1 << LAST_N) - 64'd1;
   localparam logic [CH-1:0] LAST_PAD = ~LAST_ONE[CH-1:0];
   localparam logic [CI_W-1:0] LAST_CH = CI_W'(NCH - 1);

   // low n bits set, n up to CH
   function automatic logic [CH-1:0] low_ones(input logic [CB:0] n);
      logic [CH:0] t;
      t = (ONE_C << n) - ONE_C;
      return t[CH-1:0];
   endfunction

   // configuration
   logic [lsra_pkg::CSR_W-1:0] num_regs_ff, resv_ff;

   // latched item
   logic                is_begin_ff;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [POS_BITS-1:0] end_ff, end_in;
   logic [WID_W-1:0]    w_ff, w_in;
   logic [CB-1:0]       amask_ff, amask_in;

   // allocator state
   logic [CH-1:0]    occ_ff [NCH];
   logic [CH-1:0]    occ_in [NCH];
   logic [CNT_W-1:0] live_ff, live_in;
   logic [CNT_W-1:0] act_cnt_ff, act_cnt_in;
   logic             ovf_ff, ovf_in;

   // pass counters
   logic [CNT_W-1:0]     exp_rd_ff, exp_rd_in;
   logic [CNT_W-1:0]     exp_wr_ff, exp_wr_in;
   logic                 pend_ff, pend_in;
   logic [CI_W-1:0]      top_ch_ff, top_ch_in;
   logic [AW-1:0]        top_ff, top_in;
   logic signed [AW-1:0] bmw_ff, bmw_in;
   logic [CI_W-1:0]      srch_ff, srch_in;
   logic [ADR_W-1:0]     base_ff, base_in;

   // response registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lsra_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [BASE_W-1:0]             rsp_base_ff, rsp_base_in;
   logic [LIVE_W-1:0]             rsp_live_ff, rsp_live_in;
   logic [RELIEF_W-1:0]           rsp_relief_ff, rsp_relief_in;

   // RAM ports
   logic             ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0] ram_wr_data, ram_rd_data;

   // decoded expiry entry
   logic [POS_BITS-1:0] e_end;
   logic [WID_W-1:0]    e_w;
   logic [IDX_W-1:0]    e_base;
   logic [ADR_W-1:0]    e_adr;
   logic                e_expired;
   logic                exp_issue;

   // occupancy read port and search logic
   logic [CI_W-1:0]      occ_sel;
   logic [CH-1:0]        occ_rd;
   logic [CH-1:0]        srch_rd;
   logic [CH-1:0]        wmask;
   logic signed [AW-1:0] rem;
   logic                 hit;
   logic [CB-1:0]        hit_off;
   logic                 top_nz;
   logic [CB-1:0]        top_msb;

   assign e_end     = ram_rd_data[POS_BITS-1:0];
   assign e_w       = ram_rd_data[POS_BITS +: WID_W];
   assign e_base    = ram_rd_data[POS_BITS + WID_W +: IDX_W];
   assign e_adr     = ADR_W'(e_base);
   assign e_expired = (e_end < start_ff);
   assign exp_issue = cmd.expire_step && (exp_rd_ff < act_cnt_ff);
   assign wmask     = low_ones(CB1'(w_ff));

   // select the occupancy chunk for the active pass
   always_comb begin
      if (cmd.expire_step) begin
         occ_sel = e_adr[ADR_W-1:CB];
      end else if (cmd.top_step) begin
         occ_sel = top_ch_ff;
      end else if (cmd.grant) begin
         occ_sel = base_ff[ADR_W-1:CB];
      end else begin
         occ_sel = srch_ff;
      end
   end

   assign occ_rd  = occ_ff[occ_sel];
   assign srch_rd = occ_rd | ((srch_ff == LAST_CH) ? LAST_PAD : '0);

   // highest occupied bit of the chunk under the top scan
   always_comb begin
      top_nz  = |occ_rd;
      top_msb = '0;
      for (int i = 0; i < CH; i++) begin
         if (occ_rd[i]) begin
            top_msb = CB'(i);
         end
      end
   end

   // lowest aligned free window in the chunk under search that meets the bound
   always_comb begin
      logic free_j, align_j, le_j;
      rem     = bmw_ff - $signed(AW'({srch_ff, {CB{1'b0}}}));
      hit     = 1'b0;
      hit_off = '0;
      for (int j = CH - 1; j >= 0; j--) begin
         free_j  = (((srch_rd >> j) & wmask) == '0);
         align_j = ((CB'(j) & amask_ff) == '0);
         le_j    = !rem[AW-1] && (rem[AW-2:0] >= (AW-1)'(j));
         if (free_j && align_j && le_j) begin
            hit     = 1'b1;
            hit_off = CB'(j);
         end
      end
   end

   // RAM port control: compaction write during expiry, append on grant
   always_comb begin
      ram_rd_en   = exp_issue;
      ram_rd_addr = exp_rd_ff[IDX_W-1:0];
      if (cmd.grant) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = act_cnt_ff[IDX_W-1:0];
         ram_wr_data = {base_ff[IDX_W-1:0], w_ff, end_ff};
      end else begin
         ram_wr_en   = cmd.expire_step && pend_ff && !e_expired;
         ram_wr_addr = exp_wr_ff[IDX_W-1:0];
         ram_wr_data = ram_rd_data;
      end
   end

   lsra_ram #(
      .WIDTH (ENT_W),
      .DEPTH (REGS)
   ) u_active (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values of all state
   always_comb begin
      logic [5:0]           w_raw, w_cl;
      logic [CB-1:0]        wm1;
      logic [AW-1:0]        pref_n, lo, hi, limit, sum, num, relief;
      logic signed [AW-1:0] tm1, bound;

      start_in = start_ff;
      end_in   = end_ff;
      w_in     = w_ff;
      amask_in = amask_ff;
      occ_in   = occ_ff;
      live_in  = live_ff;
      act_cnt_in = act_cnt_ff;
      ovf_in   = ovf_ff;
      exp_rd_in = exp_rd_ff;
      exp_wr_in = exp_wr_ff;
      pend_in  = pend_ff;
      top_ch_in = top_ch_ff;
      top_in   = top_ff;
      bmw_in   = bmw_ff;
      srch_in  = srch_ff;
      base_in  = base_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_relief_in = rsp_relief_ff;

      // clamp the width and derive the alignment mask
      w_raw = 6'(req_span_width);
      if (w_raw == 6'd0) begin
         w_cl = 6'd1;
      end else if (w_raw > 6'(MAX_WIDTH)) begin
         w_cl = 6'(MAX_WIDTH);
      end else begin
         w_cl = w_raw;
      end
      wm1 = CB'(w_cl - 6'd1);
      wm1 = wm1 | (wm1 >> 1);
      wm1 = wm1 | (wm1 >> 2);
      wm1 = wm1 | (wm1 >> 4);
      wm1 = wm1 | (wm1 >> 8);
      wm1 = wm1 | (wm1 >> 16);

      // reserved prefix length
      if (resv_ff != '0 && resv_ff <= num_regs_ff) begin
         pref_n = (AW'(resv_ff) < AW'(REGS)) ? AW'(resv_ff) : AW'(REGS);
      end else begin
         pref_n = '0;
      end

      limit = (AW'(num_regs_ff) < AW'(REGS)) ? AW'(num_regs_ff) : AW'(REGS);
      tm1   = $signed(top_ff) - $signed(AW'(1));
      bound = (tm1 > $signed(limit)) ? tm1 : $signed(limit);
      num   = AW'(num_regs_ff);
      sum   = AW'(live_ff) + AW'(w_ff);
      relief = (sum > num) ? (sum - num) : AW'(1);
      lo = '0;
      hi = '0;

      // take a new item
      if (cmd.accept) begin
         start_in  = req_start_position;
         end_in    = req_end_position;
         w_in      = WID_W'(w_cl);
         amask_in  = wm1;
         exp_rd_in = '0;
         exp_wr_in = '0;
         pend_in   = 1'b0;
         top_ch_in = LAST_CH;
         top_in    = '0;
         srch_in   = '0;
      end

      // clear the class and mark the reserved prefix
      if (cmd.clear_class) begin
         for (int c = 0; c < NCH; c++) begin
            lo = AW'(c * CH);
            hi = AW'((c + 1) * CH);
            if (pref_n >= hi) begin
               occ_in[c] = '1;
            end else if (pref_n <= lo) begin
               occ_in[c] = '0;
            end else begin
               occ_in[c] = low_ones(CB1'(pref_n - lo));
            end
         end
         live_in       = CNT_W'(pref_n);
         act_cnt_in    = '0;
         ovf_in        = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsra_pkg::STAT_BEGUN;
         rsp_base_in   = '0;
         rsp_live_in   = '0;
         rsp_relief_in = '0;
      end

      if (cmd.refuse) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsra_pkg::STAT_REFUSED;
         rsp_base_in   = '0;
         rsp_live_in   = '0;
         rsp_relief_in = '0;
      end

      // expiry pass: drop spans ending before the new start, compact the rest
      if (cmd.expire_step) begin
         if (exp_issue) begin
            exp_rd_in = exp_rd_ff + CNT_W'(1);
         end
         pend_in = exp_issue;
         if (pend_ff) begin
            if (e_expired) begin
               occ_in[occ_sel] = occ_rd & ~(low_ones(CB1'(e_w)) << e_adr[CB-1:0]);
               live_in = CNT_W'(AW'(live_ff) - AW'(e_w));
            end else begin
               exp_wr_in = exp_wr_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.expire_end) begin
         act_cnt_in = exp_wr_ff;
      end

      // top scan, highest chunk first
      if (cmd.top_step) begin
         if (top_nz) begin
            top_in = AW'({top_ch_ff, top_msb}) + AW'(1);
         end else if (top_ch_ff != '0) begin
            top_ch_in = top_ch_ff - CI_W'(1);
         end
      end

      // last base a window may start at
      if (cmd.bound_load) begin
         bmw_in = bound - $signed(AW'(w_ff));
      end

      // window search, lowest chunk first
      if (cmd.search_step) begin
         if (hit) begin
            base_in = {srch_ff, hit_off};
         end else if (srch_ff != LAST_CH) begin
            srch_in = srch_ff + CI_W'(1);
         end
      end

      // take the window and record the span
      if (cmd.grant) begin
         occ_in[occ_sel] = occ_rd | (wmask << base_ff[CB-1:0]);
         live_in       = CNT_W'(sum);
         act_cnt_in    = act_cnt_ff + CNT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsra_pkg::STAT_ALLOC;
         rsp_base_in   = BASE_W'(base_ff[IDX_W-1:0]);
         rsp_live_in   = '0;
         rsp_relief_in = '0;
      end

      // report the shortfall and stay overflowed
      if (cmd.fail) begin
         ovf_in        = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = lsra_pkg::STAT_NOREG;
         rsp_base_in   = '0;
         rsp_live_in   = LIVE_W'(live_ff);
         rsp_relief_in = (relief > AW'(lsra_pkg::RELIEF_MAX)) ?
                         RELIEF_W'(lsra_pkg::RELIEF_MAX) : RELIEF_W'(relief);
      end
   end

   // control state and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         num_regs_ff  <= lsra_pkg::CSR_W'(lsra_pkg::DEF_REGS);
         resv_ff      <= '0;
         for (int c = 0; c < NCH; c++) begin
            occ_ff[c] <= '0;
         end
         live_ff      <= '0;
         act_cnt_ff   <= '0;
         ovf_ff       <= 1'b0;
         exp_rd_ff    <= '0;
         exp_wr_ff    <= '0;
         pend_ff      <= 1'b0;
         top_ch_ff    <= '0;
         srch_ff      <= '0;
         is_begin_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == lsra_pkg::CSR_NUM_REGS) begin
               num_regs_ff <= csr_write_data;
            end
            if (csr_index == lsra_pkg::CSR_RESERVED) begin
               resv_ff <= csr_write_data;
            end
         end
         occ_ff       <= occ_in;
         live_ff      <= live_in;
         act_cnt_ff   <= act_cnt_in;
         ovf_ff       <= ovf_in;
         exp_rd_ff    <= exp_rd_in;
         exp_wr_ff    <= exp_wr_in;
         pend_ff      <= pend_in;
         top_ch_ff    <= top_ch_in;
         srch_ff      <= srch_in;
         if (cmd.accept) begin
            is_begin_ff <= (req_action == lsra_pkg::ACT_BEGIN);
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      end_ff        <= end_in;
      w_ff          <= w_in;
      amask_ff      <= amask_in;
      top_ff        <= top_in;
      bmw_ff        <= bmw_in;
      base_ff       <= base_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_relief_ff <= rsp_relief_in;
   end

   // status to the controller
   always_comb begin
      sts.is_begin    = is_begin_ff;
      sts.overflowed  = ovf_ff;
      sts.expire_done = !pend_ff && (exp_rd_ff == act_cnt_ff);
      sts.top_done    = top_nz || (top_ch_ff == '0);
      sts.search_hit  = hit;
      sts.search_last = (srch_ff == LAST_CH);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_base_register = rsp_base_ff;
   assign rsp_live_regs     = rsp_live_ff;
   assign rsp_shortfall     = rsp_relief_ff;

endmodule

@@ rtl/core/linear_scan_aligned_reg_alloc_top.sv @@
// Aligned span linear-scan allocator. Begin and refused items: the result
// strobe is registered from the dispatch state. Allocate: dispatch, expiry
// pass (one RAM read a cycle over the active spans), top scan, bound setup,
// window search (one 32-register chunk a cycle), then grant or fail, which
// registers the strobe; the next item is taken in the strobe cycle. Results
// cannot be stalled. Synchronous reset clears control, empties the span table
// and frees all registers at once; config resets to 256 and 0.
module linear_scan_aligned_reg_alloc_top #(
   parameter int REGS      = lsra_pkg::DEF_REGS,
   parameter int MAX_WIDTH = lsra_pkg::DEF_MAX_WIDTH,
   parameter int POS_BITS  = lsra_pkg::DEF_POS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [POS_BITS-1:0]           req_start_position,
   input  logic [POS_BITS-1:0]           req_end_position,
   input  logic [lsra_pkg::SPAN_W-1:0]   req_span_width,
   output logic                          rsp_valid,
   output logic [lsra_pkg::STATUS_W-1:0] rsp_status,
   output logic [lsra_pkg::BASE_W-1:0]   rsp_base_register,
   output logic [lsra_pkg::LIVE_W-1:0]   rsp_live_regs,
   output logic [lsra_pkg::RELIEF_W-1:0] rsp_shortfall,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [lsra_pkg::CSR_W-1:0]    csr_write_data
);

   lsra_pkg::cmd_type cmd;
   lsra_pkg::sts_type sts;

   lsra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   lsra_dp #(
      .REGS      (REGS),
      .MAX_WIDTH (MAX_WIDTH),
      .POS_BITS  (POS_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_start_position (req_start_position),
      .req_end_position   (req_end_position),
      .req_span_width     (req_span_width),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_base_register  (rsp_base_register),
      .rsp_live_regs      (rsp_live_regs),
      .rsp_shortfall      (rsp_shortfall)
   );

   // a result only shows once the sequencer is back at rest
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   // at most one result-producing command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.grant, cmd.fail, cmd.refuse, cmd.clear_class}))
      else $error("more than one result command in a cycle");

   // a grant follows a search hit
   assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> $past(sts.search_hit))
      else $error("grant without a search hit");

   // a shortfall report always asks for relief
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lsra_pkg::STAT_NOREG) |-> (rsp_shortfall != '0))
      else $error("overflow reported with zero relief");

endmodule

@@ sim/alloc_tracker_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard for the aligned span allocator: mirrors the occupancy map, the
// active span table and the two config registers, and holds predicted results.
// Depends on lsra_pkg for field widths, status codes and register indexes.
package alloc_tracker_pkg;
   import lsra_pkg::*;

   localparam int NREGS = DEF_REGS;
   localparam int WMAX  = DEF_MAX_WIDTH;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BASE_W-1:0]   base;
      logic [LIVE_W-1:0]   live;
      logic [RELIEF_W-1:0] relief;
   } grant_type;

   class alloc_tracker;
      bit          occ [NREGS];
      bit          span_on [NREGS];
      int unsigned span_base [NREGS];
      int unsigned span_len [NREGS];
      int unsigned span_last [NREGS];
      int unsigned live_regs;
      bit          overflowed;
      int unsigned num_regs;
      int unsigned reserved;
      grant_type   awaited [$];
      int unsigned failures;

      function new();
         num_regs = NREGS;
         reserved = 0;
         failures = 0;
         clear_class();
      endfunction

      function void clear_class();
         foreach (occ[i]) begin
            occ[i] = 1'b0;
            span_on[i] = 1'b0;
         end
         live_regs = 0;
         overflowed = 1'b0;
      endfunction

      function void set_register(logic idx, logic [CSR_W-1:0] value);
         if (idx == CSR_NUM_REGS) begin
            num_regs = value;
         end else begin
            reserved = value;
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // predict the result of one accepted request transfer
      function void take_request(logic act, logic [15:0] s, logic [15:0] e,
                                 logic [SPAN_W-1:0] wf);
         grant_type   g;
         int unsigned w, align, lim, top, n, sum, relief, k;
         int          hit, i, r, b;
         bit          fits, placed;
         g = '0;
         if (act == ACT_BEGIN) begin
            clear_class();
            // prefix only when it fits under the limit; clip to the store
            if (reserved > 0 && reserved <= num_regs) begin
               n = (reserved < NREGS) ? reserved : NREGS;
               for (i = 0; i < n; i++) occ[i] = 1'b1;
               live_regs = n;
            end
            g.status = STAT_BEGUN;
         end else if (overflowed) begin
            g.status = STAT_REFUSED;
         end else begin
            w = (wf == 0) ? 1 : (wf > WMAX) ? WMAX : wf;
            align = 1;
            while (align < w) align = align << 1;
            // drop spans whose last use lies before the new start
            for (i = 0; i < NREGS; i++) begin
               if (span_on[i] && span_last[i] < s) begin
                  for (r = 0; r < span_len[i]; r++) begin
                     k = span_base[i] + r;
                     if (k < NREGS && occ[k]) begin
                        occ[k] = 1'b0;
                        live_regs--;
                     end
                  end
                  span_on[i] = 1'b0;
               end
            end
            // lowest aligned free window under the limit or under the top
            lim = (num_regs < NREGS) ? num_regs : NREGS;
            top = 0;
            for (r = 0; r < NREGS; r++) if (occ[r]) top = r + 1;
            hit = -1;
            for (b = 0; b + w <= NREGS && hit < 0; b += align) begin
               fits = 1'b1;
               for (r = 0; r < w; r++) if (occ[b + r]) fits = 1'b0;
               if (fits && (b + w <= lim || b + w < top)) hit = b;
            end
            if (hit < 0) begin
               sum = live_regs + w;
               relief = (sum > num_regs) ? sum - num_regs : 1;
               if (relief > RELIEF_MAX) relief = RELIEF_MAX;
               overflowed = 1'b1;
               g.status = STAT_NOREG;
               g.live = LIVE_W'(live_regs);
               g.relief = RELIEF_W'(relief);
            end else begin
               for (r = 0; r < w; r++) occ[hit + r] = 1'b1;
               live_regs += w;
               placed = 1'b0;
               for (i = 0; i < NREGS; i++) begin
                  if (!placed && !span_on[i]) begin
                     span_on[i] = 1'b1;
                     span_base[i] = hit;
                     span_len[i] = w;
                     span_last[i] = e;
                     placed = 1'b1;
                  end
               end
               g.status = STAT_ALLOC;
               g.base = BASE_W'(hit);
            end
         end
         awaited = {awaited, g};
      endfunction

      function void compare_field(string field, logic [8:0] want, logic [8:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 100) $error("%s: expected %0d, got %0d", field, want, got);
         end
      endfunction

      // check one result transfer against the oldest prediction
      function void check_response(grant_type got);
         grant_type want;
         if (awaited.size() == 0) begin
            failures++;
            if (failures <= 100) $error("status: expected none, got %0d", got.status);
         end else begin
            want = awaited.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("base_register", want.base, got.base);
            compare_field("live_regs", want.live, got.live);
            compare_field("shortfall", want.relief, got.relief);
         end
      endfunction
   endclass

endpackage

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Top-level testbench for linear_scan_aligned_reg_alloc_top: directed and
// random requests, config writes between phases, scoreboard checking.
// Depends on lsra_pkg and alloc_tracker_pkg.
module tb;
   import lsra_pkg::*;
   import alloc_tracker_pkg::*;

   localparam int QUIET_LIMIT    = 3000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int ITEMS_PER_MODE = 392;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_action = ACT_BEGIN;
   logic [15:0]         req_start_position = '0;
   logic [15:0]         req_end_position = '0;
   logic [SPAN_W-1:0]   req_span_width = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BASE_W-1:0]   rsp_base_register;
   logic [LIVE_W-1:0]   rsp_live_regs;
   logic [RELIEF_W-1:0] rsp_shortfall;
   logic                csr_write_enable = 1'b0;
   logic                csr_index = CSR_NUM_REGS;
   logic [CSR_W-1:0]    csr_write_data = '0;

   alloc_tracker tracker = new();
   int unsigned  idle_pct = 17;
   int unsigned  items_sent = 0;
   int unsigned  quiet = 0;

   always #6 clock = ~clock;

   linear_scan_aligned_reg_alloc_top dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_start_position (req_start_position),
      .req_end_position   (req_end_position),
      .req_span_width     (req_span_width),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_base_register  (rsp_base_register),
      .rsp_live_regs      (rsp_live_regs),
      .rsp_shortfall      (rsp_shortfall),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_response({rsp_status, rsp_base_register, rsp_live_regs,
                                 rsp_shortfall});
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet = 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet++;
      end
   end

   // present one request, hold it until the transfer, then predict
   task automatic send_item(input logic act, input logic [15:0] s,
                            input logic [15:0] e, input logic [SPAN_W-1:0] w);
      int unsigned gaps;
      gaps = 0;
      while (gaps < 12 && $urandom_range(99) < idle_pct) gaps++;
      if (gaps > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gaps - 1) @(negedge clock);
      end
      @(negedge clock);
      req_action <= act;
      req_start_position <= s;
      req_end_position <= e;
      req_span_width <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.take_request(act, s, e, w);
      items_sent++;
   endtask

   task automatic alloc(input logic [15:0] s, input logic [15:0] e,
                        input logic [SPAN_W-1:0] w);
      send_item(ACT_ALLOC, s, e, w);
   endtask

   // begin ignores the other fields; fill them with noise
   task automatic begin_class();
      send_item(ACT_BEGIN, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                SPAN_W'($urandom_range(31)));
   endtask

   // drop start and wait until the block is idle with nothing outstanding
   task automatic quiesce();
      @(negedge clock) start <= 1'b0;
      while (tracker.pending() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock) tracker.set_register(idx, value);
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_W-1:0] nregs, input logic [CSR_W-1:0] resv);
      quiesce();
      write_csr(CSR_NUM_REGS, nregs);
      write_csr(CSR_RESERVED, resv);
   endtask

   function automatic logic [CSR_W-1:0] pick_limit();
      case ($urandom_range(9))
         0: return 0;
         1: return 1;
         2: return 16;
         3: return 64;
         4: return 511;
         5: return CSR_W'($urandom_range(511));
         default: return 256;
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_reserved(int unsigned nregs);
      int unsigned over;
      over = nregs + $urandom_range(1, 40);
      case ($urandom_range(5))
         0: return 0;
         1: return CSR_W'(nregs);
         2: return CSR_W'($urandom_range(nregs));
         3: return CSR_W'((over > 511) ? 511 : over);
         4: return CSR_W'($urandom_range(511));
         default: return CSR_W'($urandom_range(32));
      endcase
   endfunction

   // short directed pass over extremes and corner behavior
   task automatic directed_checks();
      // allocate straight out of reset, no begin yet
      alloc(0, 3, 1);
      begin_class();
      alloc(0, 4, 0);             // width zero acts as one
      alloc(0, 16'hFFFF, 16);
      alloc(1, 10, 31);           // width above max clamps
      alloc(2, 7, 3);
      alloc(3, 20, 5);
      alloc(6, 6, 2);             // expiry of the earliest span
      alloc(16'hFFFF, 16'hFFFF, 16);
      // small class with a prefix: grant, overflow, then refuse
      configure(16, 8);
      begin_class();
      alloc(0, 100, 8);
      alloc(1, 100, 1);
      alloc(2, 5, 1);
      // empty class
      configure(0, 0);
      begin_class();
      alloc(0, 0, 16);
      // full prefix, then limit dropped mid-class: relief saturates
      configure(256, 256);
      begin_class();
      quiesce();
      write_csr(CSR_NUM_REGS, 0);
      alloc(0, 0, 16);
      // reserved count above the limit reserves nothing
      configure(100, 300);
      begin_class();
      alloc(0, 0, 16);
      // limit and prefix above the store clip to it
      configure(511, 511);
      begin_class();
      alloc(0, 0, 1);
      // free window below an occupied register, above the limit
      configure(256, 0);
      begin_class();
      alloc(0, 1, 4);
      alloc(0, 60000, 4);
      quiesce();
      write_csr(CSR_NUM_REGS, 2);
      alloc(5, 9, 4);
      alloc(3, 9, 1);             // start below the previous one
   endtask

   // mostly ordered sequences after a begin, with noise and broken runs
   task automatic random_items(input int unsigned goal);
      logic [CSR_W-1:0] nregs;
      int unsigned      len, pos, s, e, w, pick, step;
      int               j;
      while (items_sent < goal) begin
         if ($urandom_range(99) < 25) begin
            nregs = pick_limit();
            configure(nregs, pick_reserved(nregs));
         end
         begin_class();
         len = $urandom_range(4, 60);
         pos = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(200);
         for (j = 0; j < len && items_sent < goal; j++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               begin_class();
            end else if (pick < 6) begin
               // limit change while the class is open
               quiesce();
               write_csr(CSR_NUM_REGS, pick_limit());
            end else begin
               if (pick < 14) begin
                  s = $urandom_range(65535);
               end else begin
                  s = pos;
                  step = $urandom_range(6);
                  pos = (pos + step > 65535) ? 65535 : pos + step;
               end
               pick = $urandom_range(99);
               if (pick < 10) begin
                  e = 65535;
               end else if (pick < 16) begin
                  e = $urandom_range(65535);
               end else begin
                  e = s + $urandom_range(48);
                  if (e > 65535) e = 65535;
               end
               pick = $urandom_range(99);
               if (pick < 5) w = 0;
               else if (pick < 10) w = $urandom_range(17, 31);
               else if (pick < 25) w = $urandom_range(5, 16);
               else w = $urandom_range(1, 4);
               alloc(16'(s), 16'(e), SPAN_W'(w));
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      directed_checks();
      idle_pct = 17;
      random_items(items_sent + ITEMS_PER_MODE);
      idle_pct = 57;
      random_items(items_sent + ITEMS_PER_MODE);
      idle_pct = 0;
      random_items(items_sent + ITEMS_PER_MODE);
      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
